/* src/nsla_pkg.sv */
// ---------------------------------------------------------------------------
// nsla_pkg: shared types and constants of the NAT session lookup block
// Session entry layout, status codes, register indexes and sequencer states.
// ---------------------------------------------------------------------------
package nsla_pkg;

   // One stored session: private key plus translated index and port
   typedef struct packed {
      logic [31:0] src_ip;
      logic [15:0] src_port;
      logic [3:0]  xlat_index;
      logic [15:0] xlat_port;
   } entry_type;

   typedef enum logic [1:0] {
      STATUS_HIT  = 2'd0,
      STATUS_NEW  = 2'd1,
      STATUS_FULL = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CSR_PUBLIC_IP_BASE = 2'd0,
      CSR_NUM_PUBLIC_IPS = 2'd1,
      CSR_PORT_BASE      = 2'd2,
      CSR_PORTS_PER_IP   = 2'd3
   } csr_index_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_SCAN = 1'b1
   } seq_state_type;

   // Outcome of one lookup, valid for the single cycle that done is high
   typedef struct packed {
      logic       done;
      status_type status;
   } scan_result_type;

   localparam logic [31:0] RESET_PUBLIC_IP_BASE = 32'hCB00_7101;
   localparam logic [4:0]  RESET_NUM_PUBLIC_IPS = 5'd10;
   localparam logic [15:0] RESET_PORT_BASE      = 16'd10000;
   localparam logic [15:0] RESET_PORTS_PER_IP   = 16'd5000;
   localparam logic [4:0]  ADDR_INDEX_WRAP      = 5'd16;

endpackage

/* src/nat_session_lookup_allocate.sv */
// ---------------------------------------------------------------------------
// nat_session_lookup_allocate: NAPT session lookup and allocation
// Usage:
//  - Raise start with req_private_ip/req_private_port; the item is taken at
//    an edge where start is high and busy is low. busy stays high until the
//    lookup ends; one item is worked on at a time.
//  - Exactly one result per item: rsp_strobe is high for one cycle with
//    rsp_public_ip, rsp_public_port and rsp_status (0 hit, 1 new, 2 full).
//    The receiver cannot stall; the values then hold until the next result.
//  - The table is read one entry per cycle over the filled entries only.
//    The scan ends at the first entry that matches the key or, on a miss,
//    once every filled entry has been compared; rsp_strobe is registered
//    from the cycle the scan ends. busy drops in the strobe cycle, so the
//    next item can be taken at the edge that ends it. The single read port
//    of the table sets the pace of the scan.
//  - csr_wr_en/csr_index/csr_wr_data write the configuration registers;
//    write them only while the block is idle.
//  - Reset empties the table (fill count to zero), restores the register
//    defaults and restarts the allocator at index 0, port base.
// ---------------------------------------------------------------------------
module nat_session_lookup_allocate #(
   parameter int TABLE_ENTRIES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_private_ip,
   input  logic [15:0] req_private_port,
   output logic        rsp_strobe,
   output logic [31:0] rsp_public_ip,
   output logic [15:0] rsp_public_port,
   output logic [1:0]  rsp_status,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wr_data
);
   import nsla_pkg::*;

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   // configuration registers
   logic [31:0] public_ip_base_ff;
   logic [4:0]  num_public_ips_ff;
   logic [15:0] port_base_ff;
   logic [15:0] ports_per_ip_ff;

   // result registers
   logic        rsp_strobe_ff, rsp_strobe_in;
   logic [31:0] rsp_ip_ff, rsp_ip_in;
   logic [15:0] rsp_port_ff, rsp_port_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;

   logic            rd_en, wr_en;
   logic [IDX_W-1:0] rd_addr, wr_addr;
   entry_type       rd_data, wr_data;
   scan_result_type result;
   logic [3:0]      alloc_index;
   logic [15:0]     alloc_port;
   logic            alloc_advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         public_ip_base_ff <= RESET_PUBLIC_IP_BASE;
         num_public_ips_ff <= RESET_NUM_PUBLIC_IPS;
         port_base_ff      <= RESET_PORT_BASE;
         ports_per_ip_ff   <= RESET_PORTS_PER_IP;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_PUBLIC_IP_BASE: public_ip_base_ff <= csr_wr_data;
            CSR_NUM_PUBLIC_IPS: num_public_ips_ff <= csr_wr_data[4:0];
            CSR_PORT_BASE:      port_base_ff      <= csr_wr_data[15:0];
            CSR_PORTS_PER_IP:   ports_per_ip_ff   <= csr_wr_data[15:0];
            default: ;
         endcase
      end
   end

   nsla_table #(
      .TABLE_ENTRIES(TABLE_ENTRIES),
      .IDX_W        (IDX_W)
   ) u_table (
      .clock  (clock),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data)
   );

   nsla_seq #(
      .TABLE_ENTRIES(TABLE_ENTRIES),
      .IDX_W        (IDX_W),
      .CNT_W        (CNT_W)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .lookup_ip   (req_private_ip),
      .lookup_port (req_private_port),
      .alloc_index (alloc_index),
      .alloc_port  (alloc_port),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .result      (result)
   );

   // step the allocator only when a new session was written
   assign alloc_advance = wr_en;

   nsla_alloc u_alloc (
      .clock         (clock),
      .reset         (reset),
      .advance       (alloc_advance),
      .num_public_ips(num_public_ips_ff),
      .port_base     (port_base_ff),
      .ports_per_ip  (ports_per_ip_ff),
      .alloc_index   (alloc_index),
      .alloc_port    (alloc_port)
   );

   // Build the result item in the cycle the lookup ends. A hit reads the
   // matched entry still held in the table read register; a new session
   // uses the allocator values that are being written; full gives zeros.
   always_comb begin
      rsp_strobe_in = result.done;
      rsp_status_in = rsp_status_ff;
      rsp_ip_in     = rsp_ip_ff;
      rsp_port_in   = rsp_port_ff;
      if (result.done) begin
         rsp_status_in = result.status;
         case (result.status)
            STATUS_HIT: begin
               rsp_ip_in   = public_ip_base_ff + {28'd0, rd_data.xlat_index};
               rsp_port_in = rd_data.xlat_port;
            end
            STATUS_NEW: begin
               rsp_ip_in   = public_ip_base_ff + {28'd0, alloc_index};
               rsp_port_in = alloc_port;
            end
            default: begin
               rsp_ip_in   = 32'd0;
               rsp_port_in = 16'd0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ip_ff     <= rsp_ip_in;
      rsp_port_ff   <= rsp_port_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_public_ip   = rsp_ip_ff;
   assign rsp_public_port = rsp_port_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

/* src/nsla_table.sv */
// ---------------------------------------------------------------------------
// nsla_table: session table memory
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module nsla_table #(
   parameter int TABLE_ENTRIES = 1024,
   parameter int IDX_W         = 10
) (
   input  logic                 clock,
   input  logic                 rd_en,
   input  logic [IDX_W-1:0]     rd_addr,
   output nsla_pkg::entry_type  rd_data,
   input  logic                 wr_en,
   input  logic [IDX_W-1:0]     wr_addr,
   input  nsla_pkg::entry_type  wr_data
);
   import nsla_pkg::*;

   entry_type mem [TABLE_ENTRIES];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/nsla_alloc.sv */
// ---------------------------------------------------------------------------
// nsla_alloc: round-robin public address and port allocator
// Holds the next index and port; advance steps them after a new session.
// ---------------------------------------------------------------------------
module nsla_alloc (
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  logic [4:0]  num_public_ips,
   input  logic [15:0] port_base,
   input  logic [15:0] ports_per_ip,
   output logic [3:0]  alloc_index,
   output logic [15:0] alloc_port
);
   import nsla_pkg::*;

   logic [3:0]  index_ff, index_in;
   logic [15:0] port_ff,  port_in;
   logic [16:0] port_next;
   logic [16:0] port_limit;
   logic [4:0]  index_next;

   always_comb begin
      port_next  = {1'b0, port_ff} + 17'd1;
      port_limit = {1'b0, port_base} + {1'b0, ports_per_ip};
      index_next = {1'b0, index_ff} + 5'd1;
      index_in   = index_ff;
      port_in    = port_ff;
      if (advance) begin
         // reload the base port and move to the next address at the limit
         if (port_next >= port_limit || port_next[16]) begin
            port_in = port_base;
            if (index_next >= num_public_ips || index_next >= ADDR_INDEX_WRAP) begin
               index_in = 4'd0;
            end else begin
               index_in = index_next[3:0];
            end
         end else begin
            port_in = port_next[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff <= 4'd0;
         port_ff  <= RESET_PORT_BASE;
      end else begin
         index_ff <= index_in;
         port_ff  <= port_in;
      end
   end

   assign alloc_index = index_ff;
   assign alloc_port  = port_ff;

endmodule

/* src/nsla_seq.sv */
// ---------------------------------------------------------------------------
// nsla_seq: scan sequencer with the shared key compare
// Walks the filled part of the table one entry a cycle, then hits,
// allocates the next free entry, or reports a full table.
// ---------------------------------------------------------------------------
module nsla_seq #(
   parameter int TABLE_ENTRIES = 1024,
   parameter int IDX_W         = 10,
   parameter int CNT_W         = 11
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [31:0]                  lookup_ip,
   input  logic [15:0]                  lookup_port,
   input  logic [3:0]                   alloc_index,
   input  logic [15:0]                  alloc_port,
   output logic                         rd_en,
   output logic [IDX_W-1:0]             rd_addr,
   input  nsla_pkg::entry_type          rd_data,
   output logic                         wr_en,
   output logic [IDX_W-1:0]             wr_addr,
   output nsla_pkg::entry_type          wr_data,
   output nsla_pkg::scan_result_type    result
);
   import nsla_pkg::*;

   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_ENTRIES);

   seq_state_type    state_ff, state_in;
   logic [CNT_W-1:0] ptr_ff, ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             pend_ff, pend_in;
   logic [31:0]      key_ip_ff, key_ip_in;
   logic [15:0]      key_port_ff, key_port_in;
   logic             accept;
   logic             hit_now;
   logic             miss_now;
   logic             table_full;

   assign accept     = start && (state_ff == ST_IDLE);
   assign table_full = (cnt_ff == FULL_COUNT);
   assign hit_now    = (state_ff == ST_SCAN) && pend_ff &&
                       (rd_data.src_ip == key_ip_ff) &&
                       (rd_data.src_port == key_port_ff);
   // nothing left to read and no compare outstanding
   assign miss_now   = (state_ff == ST_SCAN) && !pend_ff && (ptr_ff == cnt_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (hit_now || miss_now) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      busy               = (state_ff != ST_IDLE);
      rd_en              = (state_ff == ST_SCAN) && (ptr_ff != cnt_ff) && !hit_now;
      rd_addr            = ptr_ff[IDX_W-1:0];
      wr_en              = miss_now && !table_full;
      wr_addr            = cnt_ff[IDX_W-1:0];
      wr_data.src_ip     = key_ip_ff;
      wr_data.src_port   = key_port_ff;
      wr_data.xlat_index = alloc_index;
      wr_data.xlat_port  = alloc_port;
      result.done        = hit_now || miss_now;
      if (hit_now) begin
         result.status = STATUS_HIT;
      end else if (table_full) begin
         result.status = STATUS_FULL;
      end else begin
         result.status = STATUS_NEW;
      end
   end

   // datapath registers
   always_comb begin
      ptr_in      = ptr_ff;
      cnt_in      = cnt_ff;
      pend_in     = rd_en;
      key_ip_in   = key_ip_ff;
      key_port_in = key_port_ff;
      if (accept) begin
         ptr_in      = '0;
         key_ip_in   = lookup_ip;
         key_port_in = lookup_port;
      end else if (rd_en) begin
         ptr_in = ptr_ff + CNT_W'(1);
      end
      if (wr_en) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff      <= ptr_in;
      key_ip_ff   <= key_ip_in;
      key_port_ff <= key_port_in;
   end

endmodule
